FILE: hdl/assert_macros.svh
// assert_macros.svh: shared assertion macros, clocked on clk_i, off in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent (use |-> or |=> inside seq)
`define ASSERT_SEQ(lbl, seq, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) seq) else $error(msg);

`endif

FILE: hdl/cd3p_pkg.sv
// ----------------------------------------------------------------------------
// cd3p_pkg: circle from three points
// Types, widths and constants shared by the circle pipeline.
// ----------------------------------------------------------------------------
package cd3p_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 4;
  localparam int OUT_W      = 24;

  localparam int DIFF_W = COORD_BITS + 1;          // coordinate difference
  localparam int PP_W   = 2 * DIFF_W;              // determinant partial product
  localparam int SQ_W   = 2 * COORD_BITS + 1;      // squared norm
  localparam int DET_W  = 2 * COORD_BITS + 3;
  localparam int DEN_W  = DET_W + 1;
  localparam int PROD_W = SQ_W + 1 + DIFF_W;
  localparam int NUM_W  = PROD_W + 2;
  localparam int MAG_W  = NUM_W + FRAC_BITS;
  localparam int P_W    = DEN_W + 1;               // divider partial remainder
  localparam int DX_W   = OUT_W + 1;               // offset to point 1, root width
  localparam int RAD_W  = 2 * DX_W;                // squared distance
  localparam int R_W    = DX_W + 3;                // root remainder

  // start to done strobe, in cycles
  localparam int LATENCY = 11 + OUT_W + DX_W;

  localparam logic [OUT_W-1:0] CENTER_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] CENTER_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [OUT_W-1:0] RADIUS_MAX = {OUT_W{1'b1}};

  typedef struct packed {
    logic [COORD_BITS-1:0] point1_x;
    logic [COORD_BITS-1:0] point1_y;
    logic [COORD_BITS-1:0] point2_x;
    logic [COORD_BITS-1:0] point2_y;
    logic [COORD_BITS-1:0] point3_x;
    logic [COORD_BITS-1:0] point3_y;
  } cd3p_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] center_x;
    logic signed [OUT_W-1:0] center_y;
    logic [OUT_W-1:0]        radius;
    logic                    degenerate;
    logic                    saturated;
  } cd3p_out_t;

  // one divider lane
  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [DEN_W-1:0] den;
    logic [P_W-1:0]   prem;
    logic [OUT_W-1:0] qn;
  } cd3p_dlane_t;

  typedef struct packed {
    logic                  deg;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
  } cd3p_dside_t;

  typedef struct packed {
    logic [R_W-1:0]   rem;
    logic [DX_W-1:0]  root;
    logic [RAD_W-1:0] rad;
  } cd3p_slane_t;

  typedef struct packed {
    logic             deg;
    logic             sat;
    logic [OUT_W-1:0] cx;
    logic [OUT_W-1:0] cy;
  } cd3p_sside_t;

endpackage

FILE: hdl/cd3p_div_cell.sv
// ----------------------------------------------------------------------------
// cd3p_div_cell: divider cell
// One restoring quotient bit for the x and y lanes, registered.
// ----------------------------------------------------------------------------
module cd3p_div_cell import cd3p_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  cd3p_dside_t       side_i,
  input  cd3p_dlane_t [1:0] lane_i,
  output logic              valid_o,
  output cd3p_dside_t       side_o,
  output cd3p_dlane_t [1:0] lane_o
);

  logic              valid_q;
  cd3p_dside_t       side_q;
  cd3p_dlane_t [1:0] lane_d, lane_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [P_W-1:0] trial;
      logic           ge;
      trial = {lane_i[l].prem[P_W-2:0], lane_i[l].qn[OUT_W-1]};
      ge    = trial >= {1'b0, lane_i[l].den};
      lane_d[l]      = lane_i[l];
      lane_d[l].prem = ge ? trial - {1'b0, lane_i[l].den} : trial;
      lane_d[l].qn   = {lane_i[l].qn[OUT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_i;
    lane_q <= lane_d;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign lane_o  = lane_q;

endmodule

FILE: hdl/cd3p_sqrt_cell.sv
// ----------------------------------------------------------------------------
// cd3p_sqrt_cell: square root cell
// One root bit per cell, two radicand bits shifted in, registered.
// ----------------------------------------------------------------------------
module cd3p_sqrt_cell import cd3p_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  cd3p_sside_t side_i,
  input  cd3p_slane_t lane_i,
  output logic        valid_o,
  output cd3p_sside_t side_o,
  output cd3p_slane_t lane_o
);

  logic        valid_q;
  cd3p_sside_t side_q;
  cd3p_slane_t lane_d, lane_q;
  logic [R_W-1:0] acc, trial;
  logic           ge;

  always_comb begin
    acc   = {lane_i.rem[R_W-3:0], lane_i.rad[RAD_W-1:RAD_W-2]};
    trial = R_W'({lane_i.root, 2'b01});
    ge    = acc >= trial;
    lane_d.rem  = ge ? acc - trial : acc;
    lane_d.root = {lane_i.root[DX_W-2:0], ge};
    lane_d.rad  = {lane_i.rad[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_i;
    lane_q <= lane_d;
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign lane_o  = lane_q;

endmodule

FILE: hdl/circle_from_three_points.sv
// Throughput: one transaction per cycle; busy_o stays low, the pipeline never stalls.
// Depth is set by the divider chain (one quotient bit per cell, 24 cells) and
// the root chain (one root bit per cell, 25 cells). The receiver cannot stall.
// Reset clears the valid bits only; no result is lost or invented after reset.
// ----------------------------------------------------------------------------
// circle_from_three_points: circumcircle of three pixel points
// Fixed-point center by a chain of divider cells, radius by a chain of root cells.
// ----------------------------------------------------------------------------
module circle_from_three_points import cd3p_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  cd3p_in_t  point_i,
  output logic      done_o,
  output cd3p_out_t result_o
);

  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, vo_q;

  // stage 0: input
  cd3p_in_t in_q;
  // stage 1: differences, squares, determinant partial products
  logic signed [DIFF_W-1:0] dy23_q, dy31_q, dy12_q, dx32_q, dx13_q, dx21_q;
  logic [2*COORD_BITS-1:0]  xx1_q, yy1_q, xx2_q, yy2_q, xx3_q, yy3_q;
  logic signed [PP_W-1:0]   pp1_q, pp2_q, pp3_q, pp4_q;
  logic [COORD_BITS-1:0]    x1a_q, y1a_q;
  // stage 2: norms, determinant
  logic signed [DIFF_W-1:0] dy23b_q, dy31b_q, dy12b_q, dx32b_q, dx13b_q, dx21b_q;
  logic [SQ_W-1:0]          s1_q, s2_q, s3_q;
  logic signed [DET_W-1:0]  det2_q;
  logic [COORD_BITS-1:0]    x1b_q, y1b_q;
  // stage 3: numerator products
  logic signed [PROD_W-1:0] nx1_q, nx2_q, nx3_q, ny1_q, ny2_q, ny3_q;
  logic signed [DET_W-1:0]  det3_q;
  logic [COORD_BITS-1:0]    x1c_q, y1c_q;
  // stage 4: numerators, denominator
  logic signed [NUM_W-1:0]  numx_q, numy_q;
  logic signed [DEN_W-1:0]  den_q;
  cd3p_dside_t              side4_q;
  // stage 5: divider entry
  cd3p_dlane_t [1:0]        lane5_q;
  cd3p_dside_t              side5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v0_q <= start_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign busy_o = 1'b0;

  logic signed [DIFF_W-1:0] sx1, sy1, sx2, sy2, sx3, sy3, d_y23, d_x32;
  assign sx1   = $signed({1'b0, in_q.point1_x});
  assign sy1   = $signed({1'b0, in_q.point1_y});
  assign sx2   = $signed({1'b0, in_q.point2_x});
  assign sy2   = $signed({1'b0, in_q.point2_y});
  assign sx3   = $signed({1'b0, in_q.point3_x});
  assign sy3   = $signed({1'b0, in_q.point3_y});
  assign d_y23 = sy2 - sy3;
  assign d_x32 = sx3 - sx2;

  // stage 4 -> 5 lane setup
  cd3p_dlane_t [1:0] lane5_d;
  always_comb begin
    logic [NUM_W-1:0] an [2];
    logic [DEN_W-1:0] ad;
    logic [MAG_W-1:0] mag;
    an[0] = numx_q[NUM_W-1] ? NUM_W'(-numx_q) : NUM_W'(numx_q);
    an[1] = numy_q[NUM_W-1] ? NUM_W'(-numy_q) : NUM_W'(numy_q);
    ad    = den_q[DEN_W-1] ? DEN_W'(-den_q) : DEN_W'(den_q);
    for (int l = 0; l < 2; l++) begin
      mag = MAG_W'(an[l]) << FRAC_BITS;
      lane5_d[l].neg  = ((l == 0) ? numx_q[NUM_W-1] : numy_q[NUM_W-1]) ^ den_q[DEN_W-1];
      lane5_d[l].ovf  = (mag >> OUT_W) >= MAG_W'(ad);
      lane5_d[l].den  = ad;
      lane5_d[l].prem = P_W'(mag >> OUT_W);
      lane5_d[l].qn   = mag[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_q <= point_i;
    end
    dy23_q <= d_y23;
    dy31_q <= sy3 - sy1;
    dy12_q <= sy1 - sy2;
    dx32_q <= d_x32;
    dx13_q <= sx1 - sx3;
    dx21_q <= sx2 - sx1;
    xx1_q  <= in_q.point1_x * in_q.point1_x;
    yy1_q  <= in_q.point1_y * in_q.point1_y;
    xx2_q  <= in_q.point2_x * in_q.point2_x;
    yy2_q  <= in_q.point2_y * in_q.point2_y;
    xx3_q  <= in_q.point3_x * in_q.point3_x;
    yy3_q  <= in_q.point3_y * in_q.point3_y;
    pp1_q  <= sx1 * d_y23;
    pp2_q  <= sy1 * d_x32;
    pp3_q  <= sx2 * sy3;
    pp4_q  <= sx3 * sy2;
    x1a_q  <= in_q.point1_x;
    y1a_q  <= in_q.point1_y;

    dy23b_q <= dy23_q;
    dy31b_q <= dy31_q;
    dy12b_q <= dy12_q;
    dx32b_q <= dx32_q;
    dx13b_q <= dx13_q;
    dx21b_q <= dx21_q;
    s1_q    <= SQ_W'(xx1_q) + SQ_W'(yy1_q);
    s2_q    <= SQ_W'(xx2_q) + SQ_W'(yy2_q);
    s3_q    <= SQ_W'(xx3_q) + SQ_W'(yy3_q);
    det2_q  <= DET_W'(pp1_q) + DET_W'(pp2_q) + DET_W'(pp3_q) - DET_W'(pp4_q);
    x1b_q   <= x1a_q;
    y1b_q   <= y1a_q;

    nx1_q  <= $signed({1'b0, s1_q}) * dy23b_q;
    nx2_q  <= $signed({1'b0, s2_q}) * dy31b_q;
    nx3_q  <= $signed({1'b0, s3_q}) * dy12b_q;
    ny1_q  <= $signed({1'b0, s1_q}) * dx32b_q;
    ny2_q  <= $signed({1'b0, s2_q}) * dx13b_q;
    ny3_q  <= $signed({1'b0, s3_q}) * dx21b_q;
    det3_q <= det2_q;
    x1c_q  <= x1b_q;
    y1c_q  <= y1b_q;

    numx_q      <= NUM_W'(nx1_q) + NUM_W'(nx2_q) + NUM_W'(nx3_q);
    numy_q      <= NUM_W'(ny1_q) + NUM_W'(ny2_q) + NUM_W'(ny3_q);
    den_q       <= DEN_W'(det3_q) <<< 1;
    side4_q.deg <= det3_q == '0;
    side4_q.x1  <= x1c_q;
    side4_q.y1  <= y1c_q;

    lane5_q <= lane5_d;
    side5_q <= side4_q;
  end

  // divider chain
  logic              dv   [OUT_W+1];
  cd3p_dside_t       dside[OUT_W+1];
  cd3p_dlane_t [1:0] dlane[OUT_W+1];

  assign dv[0]    = v5_q;
  assign dside[0] = side5_q;
  assign dlane[0] = lane5_q;

  for (genvar i = 0; i < OUT_W; i++) begin : g_div
    cd3p_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv[i]),
      .side_i  (dside[i]),
      .lane_i  (dlane[i]),
      .valid_o (dv[i+1]),
      .side_o  (dside[i+1]),
      .lane_o  (dlane[i+1])
    );
  end

  // stage 6: sign and clamp; 7: offsets; 8: squares; 9: distance
  logic [OUT_W-1:0]        cx6_q, cy6_q;
  logic                    sat6_q, deg6_q;
  logic [COORD_BITS-1:0]   x16_q, y16_q;
  logic signed [DX_W-1:0]  dx7_q, dy7_q;
  cd3p_sside_t             side7_q, side8_q, side9_q;
  logic [RAD_W-1:0]        qx8_q, qy8_q, dist9_q;

  logic [OUT_W-1:0] cen_d [2];
  logic             csat_d[2];
  always_comb begin
    cd3p_dlane_t ln;
    for (int l = 0; l < 2; l++) begin
      ln = dlane[OUT_W][l];
      if (!ln.neg) begin
        csat_d[l] = ln.ovf || ln.qn[OUT_W-1];
        cen_d[l]  = csat_d[l] ? CENTER_MAX : ln.qn;
      end else begin
        csat_d[l] = ln.ovf || (ln.qn > CENTER_MIN);
        cen_d[l]  = csat_d[l] ? CENTER_MIN : OUT_W'(-ln.qn);
      end
    end
  end

  logic [OUT_W-1:0] x1s, y1s;
  assign x1s = OUT_W'(x16_q) << FRAC_BITS;
  assign y1s = OUT_W'(y16_q) << FRAC_BITS;

  logic signed [RAD_W-1:0] px, py;
  assign px = dx7_q * dx7_q;
  assign py = dy7_q * dy7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      v6_q <= dv[OUT_W];
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cx6_q  <= cen_d[0];
    cy6_q  <= cen_d[1];
    sat6_q <= csat_d[0] || csat_d[1];
    deg6_q <= dside[OUT_W].deg;
    x16_q  <= dside[OUT_W].x1;
    y16_q  <= dside[OUT_W].y1;

    dx7_q       <= $signed({cx6_q[OUT_W-1], cx6_q}) - $signed({1'b0, x1s});
    dy7_q       <= $signed({cy6_q[OUT_W-1], cy6_q}) - $signed({1'b0, y1s});
    side7_q.deg <= deg6_q;
    side7_q.sat <= sat6_q;
    side7_q.cx  <= cx6_q;
    side7_q.cy  <= cy6_q;

    qx8_q   <= RAD_W'(px);
    qy8_q   <= RAD_W'(py);
    side8_q <= side7_q;

    dist9_q <= qx8_q + qy8_q;
    side9_q <= side8_q;
  end

  // root chain
  logic        sv   [DX_W+1];
  cd3p_sside_t sside[DX_W+1];
  cd3p_slane_t slane[DX_W+1];

  assign sv[0]         = v9_q;
  assign sside[0]      = side9_q;
  assign slane[0].rem  = '0;
  assign slane[0].root = '0;
  assign slane[0].rad  = dist9_q;

  for (genvar i = 0; i < DX_W; i++) begin : g_sqrt
    cd3p_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sv[i]),
      .side_i  (sside[i]),
      .lane_i  (slane[i]),
      .valid_o (sv[i+1]),
      .side_o  (sside[i+1]),
      .lane_o  (slane[i+1])
    );
  end

  // output register
  cd3p_out_t   res_d, res_q;
  cd3p_sside_t so;
  logic        rsat;
  always_comb begin
    so   = sside[DX_W];
    rsat = slane[DX_W].root[DX_W-1];
    if (so.deg) begin
      res_d = '0;
      res_d.degenerate = 1'b1;
    end else begin
      res_d.center_x   = so.cx;
      res_d.center_y   = so.cy;
      res_d.radius     = rsat ? RADIUS_MAX : slane[DX_W].root[OUT_W-1:0];
      res_d.degenerate = 1'b0;
      res_d.saturated  = so.sat || rsat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= sv[DX_W];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = vo_q;
  assign result_o = res_q;

endmodule

FILE: hdl/cd3p_checker.sv
// ----------------------------------------------------------------------------
// cd3p_checker: port checker for circle_from_three_points
// Watches timing of done strobes, the degenerate result encoding and that busy_o stays low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cd3p_checker import cd3p_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input logic      busy_o,
  input logic      done_o,
  input cd3p_out_t result_o
);

  logic took;
  assign took = start_i && !busy_o;

  `ASSERT_SEQ(a_done_follows, took |-> ##LATENCY done_o, "transaction without result")
  `ASSERT_SEQ(a_done_caused, done_o |-> $past(took, LATENCY), "result without transaction")
  `ASSERT_HOLDS(a_deg_zero,
    !(done_o && result_o.degenerate) ||
    (result_o.center_x == '0 && result_o.center_y == '0 &&
     result_o.radius == '0 && !result_o.saturated), "degenerate result not zero")
  `ASSERT_HOLDS(a_never_busy, !busy_o, "pipeline reported busy")

endmodule

bind circle_from_three_points cd3p_checker u_cd3p_checker (.*);
